// File: sv/ssid_pkg.sv
package ssid_pkg;

    // table geometry
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W = 32;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // command codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } ssid_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } ssid_stat_t;

    // count as carried on the result, masked to five bits
    function automatic logic [4:0] held_bits(logic [CNT_W-1:0] c);
        logic [CMP_W-1:0] t;
        t = CMP_W'(c);
        return t[4:0];
    endfunction

endpackage

// File: sv/ssid_if.sv
interface ssid_cmd_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface ssid_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [4:0] held_count;

    modport source (output valid, output status, output held_count, input ready);
    modport sink (input valid, input status, input held_count, output ready);
endinterface

// File: sv/sorted_set_insert_delete_top.sv
// channel  | dir | payload                      | transfer when
// ---------+-----+------------------------------+------------------------
// cmd      | in  | func[0], value[31:0] signed  | cmd.valid && cmd.ready
// res      | out | status[1:0], held_count[4:0] | res.valid && res.ready
// apb      | in  | capacity at byte address 0   | psel && penable && pwrite
//
// an item passes through accept, compare in every cell, then shift and count
// update; the result shows the cycle after the update
// the next command is taken while a result waits; the update stage holds until
// the result register is free
// rst_n is asynchronous; it empties the table and sets capacity to 16
module sorted_set_insert_delete_top
    import ssid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ssid_cmd_if.sink           cmd,
    ssid_res_if.source         res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    ssid_cmd_t        dp_cmd;
    ssid_stat_t       dp_stat;
    logic [CAP_W-1:0] capacity_reg;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_RESET;
        else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY))
            capacity_reg <= pwdata[CAP_W-1:0];
    end

    // register read back
    assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;
    assign pready = 1'b1;

    ssid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    ssid_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (dp_cmd),
        .stat           (dp_stat),
        .in_func        (cmd.func),
        .in_value       (cmd.value),
        .capacity       (capacity_reg),
        .out_valid      (res.valid),
        .out_ready      (res.ready),
        .out_status     (res.status),
        .out_held_count (res.held_count)
    );

endmodule

// File: sv/ssid_ctrl.sv
module ssid_ctrl
    import ssid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ssid_stat_t stat,
    output ssid_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // sequencing: accept, compare, update
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                // wait for the result slot to drain
                if (stat.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: sv/ssid_dp.sv
module ssid_dp
    import ssid_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ssid_cmd_t          cmd,
    output ssid_stat_t         stat,
    input  logic               in_func,
    input  logic signed [31:0] in_value,
    input  logic [CAP_W-1:0]   capacity,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output logic [4:0]         out_held_count
);

    logic signed [KEY_W-1:0] entry_reg [DEPTH];
    logic signed [KEY_W-1:0] entry_next [DEPTH];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic signed [KEY_W-1:0] key_reg;
    logic                    func_reg;
    logic [DEPTH-1:0]        lt_reg;
    logic [DEPTH-1:0]        eq_reg;
    logic                    out_valid_reg;
    logic [1:0]              out_status_reg;
    logic [4:0]              out_count_reg;

    logic [DEPTH-1:0] held;
    logic [DEPTH-1:0] ltv;
    logic             found;
    logic             full;
    logic [CMP_W-1:0] eff_cap;
    logic [1:0]       status_next;
    logic             write_en;

    // cells below the count hold live entries
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            held[i] = CNT_W'(i) < count_reg;
    end

    // decision from the registered compare flags
    always_comb
    begin
        ltv     = lt_reg & held;
        found   = |(eq_reg & held);
        eff_cap = (CMP_W'(capacity) < CMP_W'(DEPTH)) ? CMP_W'(capacity) : CMP_W'(DEPTH);
        full    = CMP_W'(count_reg) >= eff_cap;
        if (func_reg == FUNC_INSERT)
            status_next = full ? ST_FULL : (found ? ST_DUP : ST_DONE);
        else
            status_next = found ? ST_DONE : ST_MISS;
        write_en = cmd.update && (status_next == ST_DONE);
        if (!write_en)
            count_next = count_reg;
        else if (func_reg == FUNC_INSERT)
            count_next = count_reg + 1'b1;
        else
            count_next = count_reg - 1'b1;
    end

    // per cell shift: up on insert, down on delete
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] below;
        logic signed [KEY_W-1:0] above;
        logic                    below_lt;

        if (i == 0)
        begin : g_first
            assign below    = key_reg;
            assign below_lt = 1'b1;
        end
        else
        begin : g_mid
            assign below    = entry_reg[i-1];
            assign below_lt = ltv[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign above = entry_reg[i];
        end
        else
        begin : g_up
            assign above = entry_reg[i+1];
        end

        always_comb
        begin
            if (ltv[i])
                entry_next[i] = entry_reg[i];
            else if (func_reg == FUNC_DELETE)
                entry_next[i] = above;
            else if (below_lt)
                entry_next[i] = key_reg;
            else
                entry_next[i] = below;
        end

        // entry storage and compare flags
        always_ff @(posedge clk)
        begin
            if (write_en)
                entry_reg[i] <= entry_next[i];
            if (cmd.compare)
            begin
                lt_reg[i] <= entry_reg[i] < key_reg;
                eq_reg[i] <= entry_reg[i] == key_reg;
            end
        end
    end

    // command latch and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= in_value;
            func_reg <= in_func;
        end
        if (cmd.update)
        begin
            out_status_reg <= status_next;
            out_count_reg  <= held_bits(count_next);
        end
    end

    // count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.update)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_held_count  = out_count_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(DEPTH) >= count_reg)
        else $error("entry count above table depth");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.update |=> $stable(count_reg))
        else $error("entry count moved without an update");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        write_en && (func_reg == FUNC_INSERT)
        |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("insert did not add one entry");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

    for (genvar j = 0; j < DEPTH - 1; j++)
    begin : g_order_chk
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            held[j+1] |-> entry_reg[j] < entry_reg[j+1])
            else $error("held entries out of order");
    end
`endif

endmodule

// File: verif/testbench.sv
module testbench
    import ssid_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS = 100;
    localparam int POOL_SIZE = 20;

    typedef struct {
        logic [1:0] status;
        logic [4:0] held_count;
    } reply_t;

    // mirror of the sorted table; predicts one reply per command transfer
    class sorted_set_mirror;
        logic signed [KEY_W-1:0] keys [DEPTH];
        int                      held;
        logic [CAP_W-1:0]        cap_limit;
        reply_t                  due_replies [$];
        int                      errors;

        function new();
            held = 0;
            cap_limit = CAP_RESET;
            errors = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            cap_limit = c;
        endfunction

        function int outstanding();
            return due_replies.size();
        endfunction

        function void note_command(logic f, logic signed [KEY_W-1:0] v);
            int     pos;
            int     i;
            int     eff;
            reply_t r;
            eff = (int'(cap_limit) < DEPTH) ? int'(cap_limit) : DEPTH;
            // first held slot not below the key
            pos = 0;
            while (pos < held && keys[pos] < v)
                pos++;
            if (f == FUNC_INSERT)
            begin
                // full check wins over the duplicate check
                if (held >= eff)
                    r.status = ST_FULL;
                else if (pos < held && keys[pos] == v)
                    r.status = ST_DUP;
                else
                begin
                    for (i = held; i > pos; i--)
                        keys[i] = keys[i-1];
                    keys[pos] = v;
                    held++;
                    r.status = ST_DONE;
                end
            end
            else
            begin
                if (pos >= held || keys[pos] != v)
                    r.status = ST_MISS;
                else
                begin
                    for (i = pos; i + 1 < held; i++)
                        keys[i] = keys[i+1];
                    held--;
                    r.status = ST_DONE;
                end
            end
            r.held_count = 5'(held);
            due_replies.push_back(r);
        endfunction

        function void check_reply(logic [1:0] status, logic [4:0] held_count);
            reply_t exp_r;
            if (due_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("reply with no command pending: status %0d count %0d",
                             status, held_count);
                return;
            end
            exp_r = due_replies.pop_front();
            if (status !== exp_r.status || held_count !== exp_r.held_count)
            begin
                errors++;
                if (errors <= 10)
                    $display("reply mismatch: expected status %0d count %0d, got %0d %0d",
                             exp_r.status, exp_r.held_count, status, held_count);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    bit                 no_idle;
    int                 cycles;

    sorted_set_mirror mirror = new();

    ssid_cmd_if cmd_ch ();
    ssid_res_if res_ch ();

    sorted_set_insert_delete_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side stalls at random
    always @(negedge clk)
        res_ch.ready <= no_idle || ($urandom_range(99) >= 24);

    // check every result transfer
    always @(posedge clk)
        if (rst_n && res_ch.valid && res_ch.ready)
            mirror.check_reply(res_ch.status, res_ch.held_count);

    function automatic bit take_break();
        return !no_idle && ($urandom_range(99) < 24);
    endfunction

    // one command transfer; entered and left at a falling edge
    task automatic send_cmd(logic f, logic signed [KEY_W-1:0] v);
        // valid may have dropped at the entry edge, so raise it no earlier than the next
        @(negedge clk);
        while (take_break())
            @(negedge clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= f;
        cmd_ch.value <= v;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        mirror.note_command(f, v);
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
    endtask

    // hold off until every reply is back
    task automatic wait_drained();
        while (mirror.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // capacity write, only with the table idle
    task automatic write_capacity(logic [CAP_W-1:0] c);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_CAPACITY));
        pwdata  <= PDATA_W'(c);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        mirror.set_capacity(c);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [CAP_W-1:0]        phase_caps [8];
        logic signed [KEY_W-1:0] v;
        logic                    f;
        int                      eff;
        int                      ph;
        int                      n;
        int                      k;

        phase_caps = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd16, 5'd17, 5'd8};

        // known levels from time zero
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.func   = FUNC_INSERT;
        cmd_ch.value  = '0;
        res_ch.ready  = 1'b0;
        no_idle       = 1'b0;
        cycles        = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, extremes, duplicates, misses
        send_cmd(FUNC_DELETE, 32'sd0);
        send_cmd(FUNC_INSERT, 32'sh80000000);
        send_cmd(FUNC_INSERT, 32'sh7fffffff);
        send_cmd(FUNC_INSERT, 32'sd0);
        send_cmd(FUNC_INSERT, -32'sd1);
        send_cmd(FUNC_INSERT, 32'sd1);
        send_cmd(FUNC_INSERT, 32'sh7fffffff);
        send_cmd(FUNC_INSERT, 32'sh80000000);
        send_cmd(FUNC_DELETE, 32'sd5);
        send_cmd(FUNC_DELETE, -32'sd1);
        send_cmd(FUNC_DELETE, 32'sh80000000);

        // directed: capacity lowered below the count, full beats duplicate
        write_capacity(5'd2);
        send_cmd(FUNC_INSERT, 32'sd7);
        send_cmd(FUNC_INSERT, 32'sd0);
        send_cmd(FUNC_DELETE, 32'sd1);
        send_cmd(FUNC_INSERT, 32'sd7);
        send_cmd(FUNC_DELETE, 32'sd0);
        send_cmd(FUNC_INSERT, 32'sd7);

        // directed: zero capacity refuses every insert
        write_capacity(5'd0);
        send_cmd(FUNC_INSERT, 32'sd3);
        send_cmd(FUNC_DELETE, 32'sd7);
        send_cmd(FUNC_DELETE, 32'sh7fffffff);
        send_cmd(FUNC_INSERT, 32'sd3);

        // random phases, one capacity each
        for (ph = 0; ph < 8; ph++)
        begin
            write_capacity(phase_caps[ph]);
            no_idle = (ph == 2);
            key_pool[0] = 32'sh80000000;
            key_pool[1] = 32'sh7fffffff;
            key_pool[2] = 32'sd0;
            key_pool[3] = -32'sd1;
            for (k = 4; k < POOL_SIZE; k++)
                key_pool[k] = (k < 8) ? KEY_W'($urandom_range(15)) : $urandom;
            eff = (int'(phase_caps[ph]) < DEPTH) ? int'(phase_caps[ph]) : DEPTH;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // mid-phase drain
                if (ph == 3 && n == PHASE_ITEMS / 2)
                    wait_drained();
                if ($urandom_range(9) == 0)
                begin
                    // noise
                    f = 1'($urandom_range(1));
                    v = $urandom;
                end
                else
                begin
                    // pool keys, leaning toward filling then draining the table
                    v = key_pool[$urandom_range(POOL_SIZE - 1)];
                    if (mirror.held < eff / 2 + 1)
                        f = ($urandom_range(99) < 70) ? FUNC_INSERT : FUNC_DELETE;
                    else
                        f = ($urandom_range(99) < 35) ? FUNC_INSERT : FUNC_DELETE;
                end
                send_cmd(f, v);
            end
            no_idle = 1'b0;
        end

        // drain and let the pipeline settle
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mirror.errors == 0 && mirror.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/ssid_pkg.sv
sv/ssid_if.sv
sv/ssid_ctrl.sv
sv/ssid_dp.sv
sv/sorted_set_insert_delete_top.sv
verif/testbench.sv
